// ===== rtl/ins_sort_pkg.sv =====
// ----------------------------------------------------------------------------
// ins_sort_pkg
// Shared constants, controller states and control/status bundles of the
// insertion sorter.
// ----------------------------------------------------------------------------
package ins_sort_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_START,
    ST_READ,
    ST_CMP,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;      // capture key and last flag, start insertion
    logic rd_ins;      // read entry below the insertion point
    logic shift;       // move read entry up one place
    logic place;       // write key at insertion point, count it
    logic rd_emit;     // read entry at emission index
    logic load_out;    // load output register from read data
    logic clear_batch; // empty the store for the next batch
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;      // store holds CAPACITY entries
    logic pos_zero;  // insertion point at bottom
    logic pos_one;   // insertion point one above bottom
    logic greater;   // read entry strictly greater than key
    logic last;      // current item closes the batch
    logic out_free;  // output register empty or being taken
    logic idx_last;  // emission index at greatest entry
  } status_t;

endpackage : ins_sort_pkg

// ===== rtl/insertion_sorter_unit.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_unit
// Sorts a batch of signed 32-bit values in ascending order, stable for equal
// values, and streams the sorted batch out when the closing item arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Send one value per transfer on the slave channel; raise tlast on the final
//   value of a batch. Up to CAPACITY (64) values are kept; further values of
//   the batch are dropped and every result of that batch carries tuser = 1.
//   On the closing transfer the batch is emitted on the master channel in
//   ascending order, tlast marking the greatest value.
// Operation:
//   Insertion shifts larger entries up one place per step through the single
//   write port of the store; each step reads the entry below the insertion
//   point and compares it with the value, which settles at the bottom or
//   above a smaller or equal entry. The next transfer is taken only after
//   the value is placed, or dropped when the store is already full.
//   Emission reads one entry and then loads the output register for each
//   result; the next entry is read only once the output register is free.
// Reset and stall:
//   Reset empties the batch and the output register; no clearing pass runs.
//   When the receiver stalls, hold the result in the output register and
//   pause emission; input is taken again once the last result is loaded.
// ----------------------------------------------------------------------------
module insertion_sorter_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Slave channel
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic signed [ins_sort_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                                   s_axis_tlast_i,  // last
  // Master channel
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic signed [ins_sort_pkg::DATA_W-1:0] m_axis_tdata_o,  // [31:0] sorted_value
  output logic                                   m_axis_tlast_o,  // final_res
  output logic                                   m_axis_tuser_o   // [0] dropped
);
  import ins_sort_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: one state per insertion or emission step
  ins_sort_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Store, counters and output register
  ins_sort_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_value_i    (s_axis_tdata_i),
    .in_last_i     (s_axis_tlast_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_value_o   (m_axis_tdata_o),
    .out_final_o   (m_axis_tlast_o),
    .out_dropped_o (m_axis_tuser_o)
  );

  // The store has one write port: never shift and place in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.shift && cmd.place))
    else $error("shift and place issued together");

  // A result is loaded only from data read in the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> $past(cmd.rd_emit))
    else $error("output loaded without a store read");

  // After a transfer is taken, hold off the next one while it is inserted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken during insertion");

endmodule : insertion_sorter_unit

// ===== rtl/ins_sort_dp.sv =====
// ----------------------------------------------------------------------------
// ins_sort_dp
// Datapath: sorted store, key and index registers, output register.
// ----------------------------------------------------------------------------
module ins_sort_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ins_sort_pkg::cmd_t                     cmd_i,
  output ins_sort_pkg::status_t                  status_o,
  input  logic signed [ins_sort_pkg::DATA_W-1:0] in_value_i,
  input  logic                                   in_last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [ins_sort_pkg::DATA_W-1:0] out_value_o,
  output logic                                   out_final_o,
  output logic                                   out_dropped_o
);
  import ins_sort_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic              we;

  logic signed [DATA_W-1:0] key_q;
  logic                     last_q;
  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic [ADDR_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic                     ovf_q, ovf_d;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     out_final_q;
  logic                     out_dropped_q;
  logic [CNT_W-1:0]         fill_m1;

  assign fill_m1 = fill_q - CNT_W'(1);

  assign raddr = cmd_i.rd_emit ? idx_q : pos_q - ADDR_W'(1);
  assign we    = cmd_i.shift | cmd_i.place;
  assign waddr = pos_q;
  assign wdata = cmd_i.shift ? rdata_q : key_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.rd_ins || cmd_i.rd_emit) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q  <= in_value_i;
      last_q <= in_last_i;
    end
    if (cmd_i.load_out) begin
      out_value_q   <= $signed(rdata_q);
      out_final_q   <= status_o.idx_last;
      out_dropped_q <= ovf_q;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    idx_d  = idx_q;
    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (cmd_i.accept) begin
      pos_d = fill_q[ADDR_W-1:0];
      if (fill_q == CNT_W'(CAPACITY)) begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.shift) begin
      pos_d = pos_q - ADDR_W'(1);
    end
    if (cmd_i.place) begin
      fill_d = fill_q + CNT_W'(1);
    end
    if (cmd_i.load_out) begin
      idx_d = idx_q + ADDR_W'(1);
    end
    if (cmd_i.clear_batch) begin
      idx_d  = '0;
      fill_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      idx_q  <= idx_d;
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.full     = (fill_q == CNT_W'(CAPACITY));
    status_o.pos_zero = (pos_q == '0);
    status_o.pos_one  = (pos_q == ADDR_W'(1));
    status_o.greater  = ($signed(rdata_q) > key_q);
    status_o.last     = last_q;
    status_o.out_free = !out_valid_q || out_ready_i;
    status_o.idx_last = (idx_q == fill_m1[ADDR_W-1:0]);
  end

  assign out_valid_o   = out_valid_q;
  assign out_value_o   = out_value_q;
  assign out_final_o   = out_final_q;
  assign out_dropped_o = out_dropped_q;

endmodule : ins_sort_dp

// ===== rtl/ins_sort_ctrl.sv =====
// ----------------------------------------------------------------------------
// ins_sort_ctrl
// Controller: sequences insertion steps and the emission of a batch.
// ----------------------------------------------------------------------------
module ins_sort_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ins_sort_pkg::status_t status_i,
  output ins_sort_pkg::cmd_t    cmd_o
);
  import ins_sort_pkg::*;

  state_e state_q, state_d;
  state_e after_ins;

  assign after_ins = status_i.last ? ST_EMIT_RD : ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_INS_START;
        end
      end
      ST_INS_START: begin
        if (status_i.full) begin
          state_d = after_ins;
        end else if (status_i.pos_zero) begin
          state_d = ST_PLACE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_CMP;
      ST_CMP: begin
        if (!status_i.greater) begin
          state_d = after_ins;
        end else if (status_i.pos_one) begin
          state_d = ST_PLACE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_PLACE: state_d = after_ins;
      ST_EMIT_RD: begin
        if (status_i.out_free) begin
          state_d = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_d = status_i.idx_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: cmd_o.rd_ins = 1'b1;
      ST_CMP: begin
        cmd_o.shift = status_i.greater;
        cmd_o.place = !status_i.greater;
      end
      ST_PLACE: cmd_o.place = 1'b1;
      ST_EMIT_RD: cmd_o.rd_emit = status_i.out_free;
      ST_EMIT_LD: begin
        cmd_o.load_out    = 1'b1;
        cmd_o.clear_batch = status_i.idx_last;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule : ins_sort_ctrl

// ===== tb/sorted_batch_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_batch_checker
// Watches both stream channels of the insertion sorter, keeps its own sorted
// copy of the current batch and compares every emitted result with it.
// ----------------------------------------------------------------------------
module sorted_batch_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_tvalid_i,
  input  logic                                   s_tready_i,
  input  logic signed [ins_sort_pkg::DATA_W-1:0] s_tdata_i,   // [31:0] value
  input  logic                                   s_tlast_i,   // last
  input  logic                                   m_tvalid_i,
  input  logic                                   m_tready_i,
  input  logic signed [ins_sort_pkg::DATA_W-1:0] m_tdata_i,   // [31:0] sorted_value
  input  logic                                   m_tlast_i,   // final_res
  input  logic                                   m_tuser_i,   // [0] dropped
  output int                                     fault_count_o,
  output int                                     pending_o
);
  import ins_sort_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     final_res;
    logic                     dropped;
  } sorted_item_t;

  logic signed [DATA_W-1:0] batch_store [CAPACITY];
  int unsigned              batch_fill;
  logic                     batch_overflow;
  sorted_item_t             emit_due_q [$];
  int unsigned              results_seen;
  int                       faults = 0;

  assign fault_count_o = faults;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
    faults++;
  endtask

  // Shift every strictly greater entry up, so equal values stay in arrival order
  task automatic insert_sorted(input logic signed [DATA_W-1:0] key);
    int unsigned pos;
    pos = batch_fill;
    while (pos > 0 && batch_store[pos-1] > key) begin
      batch_store[pos] = batch_store[pos-1];
      pos--;
    end
    batch_store[pos] = key;
    batch_fill++;
  endtask

  // Queue the whole batch in ascending order, then empty it
  task automatic release_batch();
    sorted_item_t item;
    for (int unsigned k = 0; k < batch_fill; k++) begin
      item.value     = batch_store[k];
      item.final_res = (k + 1 == batch_fill);
      item.dropped   = batch_overflow;
      emit_due_q.push_back(item);
    end
    batch_fill     = 0;
    batch_overflow = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sorted_item_t want;
    if (!rst_ni) begin
      batch_fill     = 0;
      batch_overflow = 1'b0;
      results_seen   = 0;
      emit_due_q.delete();
      pending_o     <= 0;
    end else begin
      // Results first: a transfer in the same cycle can only add to the queue tail
      if (m_tvalid_i && m_tready_i) begin
        if (emit_due_q.size() == 0) begin
          report_mismatch($sformatf("unexpected %0d last=%b dropped=%b",
                                    m_tdata_i, m_tlast_i, m_tuser_i));
        end else begin
          want = emit_due_q.pop_front();
          if (m_tdata_i !== want.value || m_tlast_i !== want.final_res ||
              m_tuser_i !== want.dropped) begin
            report_mismatch($sformatf("got %0d/%b/%b, want %0d/%b/%b",
                                      m_tdata_i, m_tlast_i, m_tuser_i,
                                      want.value, want.final_res, want.dropped));
          end
        end
        results_seen++;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (batch_fill < CAPACITY) begin
          insert_sorted(s_tdata_i);
        end else begin
          batch_overflow = 1'b1;
        end
        if (s_tlast_i) begin
          release_batch();
        end
      end
      pending_o <= emit_due_q.size();
    end
  end

endmodule : sorted_batch_checker

// ===== tb/insertion_sorter_unit_tb.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_unit_tb
// Sends batches of signed values to the insertion sorter with random gaps and
// receiver stalls, including a long receiver hold-off and batches that exceed
// the store capacity; the checker beside the block predicts the sorted output.
// ----------------------------------------------------------------------------
module insertion_sorter_unit_tb;
  import ins_sort_pkg::*;

  // Stimulus volume and phase points, counted in random-part transfers, and the hold-off length
  localparam int unsigned RANDOM_ITEMS = 420;
  localparam int unsigned CALM_FROM    = 360;
  localparam int unsigned HOLD_AFTER   = 80;
  localparam int unsigned HOLD_CYCLES  = 300;
  // Drain allowance: enough for one full batch of results, plus margin
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 16;
  // Run length limit for the hang guard below
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    VAL_ANY,      // any 32-bit pattern
    VAL_CLUSTER,  // small range around zero, many repeats
    VAL_EDGE      // at or next to the signed extremes
  } value_mode_e;

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic signed [DATA_W-1:0] s_tdata  = '0;
  logic                     s_tlast  = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic signed [DATA_W-1:0] m_tdata;
  logic                     m_tlast;
  logic                     m_tuser;

  int          faults;
  int          pending;
  int unsigned items_sent    = 0;
  int unsigned directed_sent = 0;
  int unsigned send_idle_pct = 0;
  logic        calm          = 1'b0;
  logic        hold_off      = 1'b0;
  int unsigned cycle_count   = 0;

  insertion_sorter_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  sorted_batch_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tlast_i     (s_tlast),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tlast_i     (m_tlast),
    .m_tuser_i     (m_tuser),
    .fault_count_o (faults),
    .pending_o     (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset from the start, then release it for good
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Guard against a hung block
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [DATA_W-1:0] pick_value(input value_mode_e mode);
    logic [DATA_W-1:0] v;
    case (mode)
      VAL_CLUSTER: begin
        v = $urandom_range(0, 15) - 8;
      end
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = 32'h8000_0000 + $urandom_range(0, 3);
          default: v = 32'h7fff_ffff - $urandom_range(0, 3);
        endcase
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  // Offer one value and hold it until the block takes the transfer; then
  // maybe drop valid for a short burst. Valid is never lowered and raised in
  // the same step: it only drops when a gap follows.
  task automatic offer(input logic [DATA_W-1:0] value, input logic last);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 9);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic offer_batch(input int unsigned len, input value_mode_e mode);
    for (int unsigned k = 0; k < len; k++) begin
      offer(pick_value(mode), k + 1 == len);
    end
  endtask

  // Receiver: random stall bursts whose density changes from phase to phase;
  // the long hold-off overrides everything, and the calm tail starts no new stalls
  initial begin
    int unsigned stall_left;
    int unsigned stall_pct;
    int unsigned phase_left;
    stall_left = 0;
    stall_pct  = 0;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          2:       stall_pct = 30;
          default: stall_pct = 60;
        endcase
        phase_left = 64;
      end
      phase_left--;
      if (hold_off) begin
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 8);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off: the sender keeps offering, so the block ends up
  // with results stuck at its output and its input stalled
  initial begin
    wait (rst_n && items_sent >= directed_sent + HOLD_AFTER && directed_sent > 0);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Sender and verdict
  initial begin
    int unsigned len;
    int unsigned batch_no;
    value_mode_e mode;
    wait (rst_n);
    @(posedge clk);

    // Directed: single-value batches at both extremes
    offer(32'h7fff_ffff, 1'b1);
    offer(32'h8000_0000, 1'b1);
    // Repeats and extremes mixed in one batch
    offer(32'd5,         1'b0);
    offer(32'hffff_ffff, 1'b0);
    offer(32'h7fff_ffff, 1'b0);
    offer(32'h8000_0000, 1'b0);
    offer(32'd0,         1'b0);
    offer(32'hffff_ffff, 1'b0);
    offer(32'd5,         1'b1);
    // Strictly descending: every insertion shifts the whole store
    for (int k = 0; k < 7; k++) begin
      offer(3 - k, k == 6);
    end
    // Already ascending: no shifts at all
    for (int k = 0; k < 5; k++) begin
      offer(k - 2, k == 4);
    end
    directed_sent = items_sent;

    // Random batches: mostly short, a few at and beyond capacity
    batch_no = 0;
    while (items_sent < directed_sent + RANDOM_ITEMS) begin
      case (batch_no)
        2:       len = CAPACITY;
        5:       len = CAPACITY + 1;
        9:       len = CAPACITY + 8;
        default: len = ($urandom_range(0, 24) == 0) ?
                       $urandom_range(CAPACITY - 4, CAPACITY + 12) :
                       $urandom_range(1, 12);
      endcase
      mode = value_mode_e'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0, 1:    send_idle_pct = 0;
        2:       send_idle_pct = 15;
        default: send_idle_pct = 40;
      endcase
      if (!calm && items_sent >= directed_sent + CALM_FROM) begin
        calm <= 1'b1;
      end
      offer_batch(len, mode);
      batch_no++;
    end
    s_tvalid <= 1'b0;

    // Let the checker see the closing transfer, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : insertion_sorter_unit_tb

// ===== insertion_sorter_unit.f =====
rtl/ins_sort_pkg.sv
rtl/ins_sort_dp.sv
rtl/ins_sort_ctrl.sv
rtl/insertion_sorter_unit.sv
tb/sorted_batch_checker.sv
tb/insertion_sorter_unit_tb.sv
